### hw/rtl/dtd_pkg.sv
// Shared types and constants for the date-time difference block.
// Holds the channel payload structs, the stage-enable struct and the month table.
// Depends on nothing; every other file imports it.
package dtd_pkg;

	typedef struct packed {
		logic [4:0]  first_hour;
		logic [5:0]  first_minute;
		logic [5:0]  first_second;
		logic [4:0]  first_day;
		logic [3:0]  first_month;
		logic [13:0] first_year;
		logic [4:0]  second_hour;
		logic [5:0]  second_minute;
		logic [5:0]  second_sec;
		logic [4:0]  second_day;
		logic [3:0]  second_month;
		logic [13:0] second_year;
	} dates_t;

	typedef struct packed {
		logic [38:0] first_serial;
		logic [38:0] second_serial;
		logic [38:0] diff_seconds;
		logic [21:0] diff_days;
	} result_t;

	// Load enables for the three register stages of the serial converter.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} ser_en_t;

	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [5:0]  SecsPerMin  = 6'd60;
	localparam logic [8:0]  DaysPerYear = 9'd365;
	localparam logic [6:0]  Century     = 7'd100;
	localparam logic [3:0]  MonthDec    = 4'd12;
	localparam logic [3:0]  MonthMar    = 4'd3;

	// x / 100 for x below 2^14 is (x * 5243) >> 19, exactly.
	localparam logic [12:0] Div100Mul   = 13'd5243;

	// 86400 = 128 * 675. Dividing by 675 uses floor(2^33 / 675); the estimate
	// is at most one low and is fixed by one compare.
	localparam logic [23:0] Div675Mul   = 24'd12725829;
	localparam logic [9:0]  Div675      = 10'd675;
	localparam logic [21:0] DaysMax     = 22'h3FFFFF;

	// Days in the months before the given one, month 1 to 12.
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### hw/rtl/dtd_serial.sv
// Three-stage converter from one date-time to seconds since 0001-01-01 00:00:00.
// Stage one scales the year, stage two sums the day count, stage three makes seconds.
// Depends on dtd_pkg.
module dtd_serial (
	input  logic             clk,
	input  dtd_pkg::ser_en_t en,
	input  logic [4:0]       hour,
	input  logic [5:0]       minute,
	input  logic [5:0]       sec,
	input  logic [4:0]       day,
	input  logic [3:0]       month,
	input  logic [13:0]      year,
	output logic [38:0]      serial
);
	import dtd_pkg::*;

	logic [13:0] yr;
	logic [13:0] ym1;
	logic [3:0]  mon;
	logic [4:0]  dy;

	logic [26:0] ym1_div_s1;
	logic [26:0] yr_div_s1;
	logic [13:0] ym1_s1;
	logic [13:0] yr_s1;
	logic [22:0] y365_s1;
	logic [16:0] tod_s1;
	logic [3:0]  mon_s1;
	logic [4:0]  day_s1;

	logic [7:0]  cent_ym1;
	logic [7:0]  cent_yr;
	logic [12:0] leaps;
	logic [13:0] yr_rem;
	logic        leap;
	logic [22:0] days;

	logic [22:0] days_s2;
	logic [16:0] tod_s2;
	logic [38:0] serial_s3;

	// Zero day, month and year count as the first; months past December as December.
	always_comb begin
		yr  = (year == 14'd0) ? 14'd1 : year;
		ym1 = yr - 14'd1;
		if (month == 4'd0) begin
			mon = 4'd1;
		end else if (month > MonthDec) begin
			mon = MonthDec;
		end else begin
			mon = month;
		end
		dy = (day == 5'd0) ? 5'd1 : day;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ym1_div_s1 <= 27'(ym1) * 27'(Div100Mul);
			yr_div_s1  <= 27'(yr) * 27'(Div100Mul);
			ym1_s1     <= ym1;
			yr_s1      <= yr;
			y365_s1    <= 23'(ym1) * 23'(DaysPerYear);
			tod_s1     <= 17'(hour) * 17'(SecsPerHour) + 17'(minute) * 17'(SecsPerMin)
				+ 17'(sec);
			mon_s1     <= mon;
			day_s1     <= dy;
		end
	end

	// Leap years before this one: y/4 - y/100 + y/400, with y/400 taken from y/100.
	always_comb begin
		cent_ym1 = ym1_div_s1[26:19];
		cent_yr  = yr_div_s1[26:19];
		leaps    = 13'(ym1_s1[13:2]) - 13'(cent_ym1) + 13'(cent_ym1[7:2]);
		yr_rem   = yr_s1 - 14'(cent_yr) * 14'(Century);
		leap     = (yr_s1[1:0] == 2'd0) && ((yr_rem != 14'd0) || (cent_yr[1:0] == 2'd0));
		days     = y365_s1 + 23'(leaps) + 23'(days_before(mon_s1))
			+ 23'(leap && (mon_s1 >= MonthMar)) + 23'(day_s1 - 5'd1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			days_s2 <= days;
			tod_s2  <= tod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			serial_s3 <= 39'(40'(days_s2) * 40'(SecsPerDay) + 40'(tod_s2));
		end
	end

	assign serial = serial_s3;

endmodule

### hw/rtl/date_time_difference.sv
// Gregorian date-time difference: two date-times in, serial seconds and difference out.
// The input channel carries a dates_t pair; the result channel carries a result_t.
// Both channels transfer when valid is high and stall is low at a rising edge of clk.
// Each date-time becomes seconds since 0001-01-01 00:00:00; the block returns both
// serials, their absolute difference, and whole days (saturating at the 22-bit maximum).
// The pipeline has six register stages: three in each serial converter, then the
// difference, the reciprocal multiply by 1/675, and the quotient fix-up with saturation.
// Throughput is one pair per cycle while the receiver does not stall; the multiplies
// in the converter and divider set the stage count.
// Reset (arst_n low) clears the stage valid bits only; no clearing pass is needed.
// When the receiver stalls, the last stage holds its result and earlier stages keep
// filling empty slots; the input stalls only once the stage behind it is full and
// cannot move. Nothing is dropped or repeated.
module date_time_difference (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dates_valid,
	output logic              dates_stall,
	input  dtd_pkg::dates_t   dates,
	output logic              result_valid,
	input  logic              result_stall,
	output dtd_pkg::result_t  result
);
	import dtd_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	ser_en_t ser_en;

	logic [38:0] ser_a;
	logic [38:0] ser_b;

	logic [38:0] a_s4, b_s4, diff_s4;
	logic [38:0] a_s5, b_s5, diff_s5;
	logic [31:0] x_s5;
	logic [22:0] qest_s5;
	logic [55:0] prod;

	logic [31:0] rem;
	logic [23:0] quot;
	result_t     res_s6;

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		rdy_s6 = !vld_s6 || !result_stall;
		rdy_s5 = !vld_s5 || rdy_s6;
		rdy_s4 = !vld_s4 || rdy_s5;
		rdy_s3 = !vld_s3 || rdy_s4;
		rdy_s2 = !vld_s2 || rdy_s3;
		rdy_s1 = !vld_s1 || rdy_s2;
	end

	assign ser_en      = '{s1: rdy_s1, s2: rdy_s2, s3: rdy_s3};
	assign dates_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= dates_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	dtd_serial u_ser_a (
		.clk    (clk),
		.en     (ser_en),
		.hour   (dates.first_hour),
		.minute (dates.first_minute),
		.sec    (dates.first_second),
		.day    (dates.first_day),
		.month  (dates.first_month),
		.year   (dates.first_year),
		.serial (ser_a)
	);

	dtd_serial u_ser_b (
		.clk    (clk),
		.en     (ser_en),
		.hour   (dates.second_hour),
		.minute (dates.second_minute),
		.sec    (dates.second_sec),
		.day    (dates.second_day),
		.month  (dates.second_month),
		.year   (dates.second_year),
		.serial (ser_b)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			a_s4    <= ser_a;
			b_s4    <= ser_b;
			diff_s4 <= (ser_a >= ser_b) ? (ser_a - ser_b) : (ser_b - ser_a);
		end
	end

	// The low seven bits are the power-of-two part of 86400 and drop out of the quotient.
	assign prod = 56'(diff_s4[38:7]) * 56'(Div675Mul);

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			diff_s5 <= diff_s4;
			x_s5    <= diff_s4[38:7];
			qest_s5 <= prod[55:33];
		end
	end

	// The estimate is exact or one low; a remainder of 675 or more means one more day.
	always_comb begin
		rem  = x_s5 - 32'(qest_s5) * 32'(Div675);
		quot = 24'(qest_s5) + 24'(rem >= 32'(Div675));
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			res_s6.first_serial  <= a_s5;
			res_s6.second_serial <= b_s5;
			res_s6.diff_seconds  <= diff_s5;
			res_s6.diff_days     <= (quot[23:22] != 2'd0) ? DaysMax : quot[21:0];
		end
	end

	assign result_valid = vld_s6;
	assign result       = res_s6;

	a_diff_abs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.diff_seconds ==
			((result.first_serial >= result.second_serial)
				? (result.first_serial - result.second_serial)
				: (result.second_serial - result.first_serial)))
		else $error("difference does not match the two serial values");

	a_days_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.diff_days != DaysMax)) |->
			((39'(result.diff_days) * 39'(SecsPerDay) <= result.diff_seconds) &&
			(result.diff_seconds - 39'(result.diff_days) * 39'(SecsPerDay)
				< 39'(SecsPerDay))))
		else $error("day count is not the truncated quotient of the difference");

	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !rdy_s6) |=> vld_s5)
		else $error("stage five item lost while the output stage was blocked");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		dates_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6))
		else $error("input stalled while the pipeline has an empty stage");

endmodule

### dv/date_time_difference_test.sv
// Self-checking testbench for date_time_difference: a table of dates, then random pairs.
// Results are tabled or predicted from the Gregorian calendar; checked field by field.
// Depends on dtd_pkg for the channel structs and on the date_time_difference RTL.
module date_time_difference_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtd_pkg::*;

	// One date-time in the same field order as each half of dates_t.
	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  sec;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_time_t;

	typedef struct packed {
		date_time_t first_dt;
		date_time_t second_dt;
		bit         has_answer;
		result_t    answer;
	} directed_row_t;

	localparam longint unsigned DAY_SECONDS = 86400;
	localparam longint unsigned DAYS_LIMIT  = 64'h3F_FFFF;
	localparam logic [38:0]     LAST_SERIAL = 39'd315537897599;
	localparam int unsigned     MONTH_START [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	localparam date_time_t EPOCH      = '{0, 0, 0, 1, 1, 1};
	localparam date_time_t ALL_ZERO   = '{0, 0, 0, 0, 0, 0};
	localparam date_time_t LAST_VALID = '{23, 59, 59, 31, 12, 9999};
	localparam date_time_t FIELD_MAX  = '{31, 63, 63, 31, 15, 16383};

	localparam int NUM_ROWS = 23;
	localparam directed_row_t DIRECTED [NUM_ROWS] = '{
		'{EPOCH, EPOCH, 1'b1, '0},
		'{ALL_ZERO, ALL_ZERO, 1'b1, '0},
		'{ALL_ZERO, EPOCH, 1'b1, '0},
		'{'{0, 0, 0, 2, 1, 1}, EPOCH, 1'b1, '{39'd86400, 39'd0, 39'd86400, 22'd1}},
		'{EPOCH, '{0, 0, 1, 1, 1, 1}, 1'b1, '{39'd0, 39'd1, 39'd1, 22'd0}},
		'{LAST_VALID, EPOCH, 1'b1, '{LAST_SERIAL, 39'd0, LAST_SERIAL, 22'd3652058}},
		'{EPOCH, LAST_VALID, 1'b1, '{39'd0, LAST_SERIAL, LAST_SERIAL, 22'd3652058}},
		'{LAST_VALID, LAST_VALID, 1'b1, '{LAST_SERIAL, LAST_SERIAL, 39'd0, 22'd0}},
		'{FIELD_MAX, EPOCH, 1'b0, '0},
		'{ALL_ZERO, FIELD_MAX, 1'b0, '0},
		'{FIELD_MAX, FIELD_MAX, 1'b0, '0},
		'{'{0, 0, 0, 5, 13, 2023}, '{0, 0, 0, 5, 12, 2023}, 1'b0, '0},
		'{'{0, 0, 0, 5, 14, 2023}, '{12, 0, 0, 5, 15, 2023}, 1'b0, '0},
		'{'{0, 0, 0, 31, 2, 2023}, '{0, 0, 0, 3, 3, 2023}, 1'b0, '0},
		'{'{23, 59, 59, 28, 2, 2000}, '{0, 0, 0, 1, 3, 2000}, 1'b0, '0},
		'{'{0, 0, 0, 28, 2, 1900}, '{0, 0, 0, 1, 3, 1900}, 1'b0, '0},
		'{'{12, 0, 0, 29, 2, 2004}, '{12, 0, 0, 1, 3, 2004}, 1'b0, '0},
		'{'{0, 0, 0, 28, 2, 2100}, '{0, 0, 0, 1, 3, 2400}, 1'b0, '0},
		'{'{31, 63, 63, 15, 6, 2020}, '{7, 4, 3, 16, 6, 2020}, 1'b0, '0},
		'{'{0, 0, 0, 1, 1, 16383}, '{0, 0, 0, 1, 1, 16382}, 1'b0, '0},
		'{'{0, 0, 0, 31, 12, 400}, '{0, 0, 0, 1, 1, 401}, 1'b0, '0},
		'{'{10, 30, 0, 1, 3, 1600}, '{0, 0, 0, 29, 2, 1600}, 1'b0, '0},
		'{'{21, 42, 21, 21, 10, 10922}, '{10, 21, 42, 10, 5, 5461}, 1'b0, '0}
	};

	// Flow-control phases for the random part: sender idle and receiver stall percentages.
	localparam int NUM_PHASES = 4;
	localparam int PHASE_ITEMS = 125;
	localparam int SEND_IDLE [NUM_PHASES] = '{0, 76, 0, 34};
	localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 76, 34};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    dates_valid;
	logic    dates_stall;
	dates_t  dates;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	result_t     pending_results [$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int unsigned dates_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;

	date_time_difference uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.dates_valid  (dates_valid),
		.dates_stall  (dates_stall),
		.dates        (dates),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit leap_year(input longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic logic [38:0] date_to_seconds(input date_time_t t);
		longint unsigned y, m, d, prior, days;
		y = (t.year == 14'd0) ? 64'd1 : 64'(t.year);
		m = (t.month == 4'd0) ? 64'd1 : ((t.month > 4'd12) ? 64'd12 : 64'(t.month));
		d = (t.day == 5'd0) ? 64'd1 : 64'(t.day);
		prior = y - 1;
		days = prior * 365 + prior / 4 - prior / 100 + prior / 400 + MONTH_START[m - 1];
		if (leap_year(y) && m >= 3) begin
			days++;
		end
		days += d - 1;
		return 39'(days * DAY_SECONDS + 64'(t.hour) * 64'd3600 + 64'(t.minute) * 64'd60
			+ 64'(t.sec));
	endfunction

	function automatic result_t expected_result(input dates_t pair);
		date_time_t a, b;
		longint unsigned whole_days;
		result_t r;
		{a, b} = pair;
		r.first_serial = date_to_seconds(a);
		r.second_serial = date_to_seconds(b);
		r.diff_seconds = (r.first_serial > r.second_serial) ?
			r.first_serial - r.second_serial : r.second_serial - r.first_serial;
		whole_days = r.diff_seconds / DAY_SECONDS;
		r.diff_days = 22'((whole_days > DAYS_LIMIT) ? DAYS_LIMIT : whole_days);
		return r;
	endfunction

	function automatic date_time_t calendar_date_time();
		date_time_t t;
		t.hour = 5'($urandom_range(0, 23));
		t.minute = 6'($urandom_range(0, 59));
		t.sec = 6'($urandom_range(0, 59));
		t.day = 5'($urandom_range(1, 31));
		t.month = 4'($urandom_range(1, 12));
		t.year = 14'($urandom_range(1, 9999));
		// Century years exercise both the hundred and the four-hundred rule.
		if ($urandom_range(0, 3) == 0) begin
			t.year = 14'(100 * $urandom_range(1, 99));
		end
		return t;
	endfunction

	function automatic date_time_t raw_date_time();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[$bits(date_time_t)-1:0];
	endfunction

	function automatic dates_t random_dates();
		date_time_t a, b;
		int mode;
		mode = int'($urandom_range(0, 99));
		a = calendar_date_time();
		if (mode < 55) begin
			b = calendar_date_time();
		end else if (mode < 85) begin
			// Nearby date-times give small differences and cross month ends.
			b = a;
			if ($urandom_range(0, 1)) b.day = 5'($urandom_range(1, 31));
			if ($urandom_range(0, 1)) b.month = 4'($urandom_range(1, 12));
			if ($urandom_range(0, 1)) b.hour = 5'($urandom_range(0, 23));
			if ($urandom_range(0, 1)) b.minute = 6'($urandom_range(0, 59));
			if ($urandom_range(0, 1)) b.sec = 6'($urandom_range(0, 59));
			if ($urandom_range(0, 3) == 0) b.year = a.year + 14'd1;
		end else begin
			a = raw_date_time();
			b = ($urandom_range(0, 1)) ? raw_date_time() : calendar_date_time();
		end
		return {a, b};
	endfunction

	// Entered at a falling edge; returns at the falling edge after the transfer.
	task automatic send_dates(input dates_t pair, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			dates_valid <= 1'b0;
			@(negedge clk);
		end
		dates_valid <= 1'b1;
		dates <= pair;
		do @(posedge clk); while (dates_stall);
		pending_results.push_back(want);
		dates_sent++;
		@(negedge clk);
	endtask

	task automatic compare_field(input string field, input logic [38:0] want,
			input logic [38:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1 && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result %h arrived with none expected", $time, result);
			end else begin
				want = pending_results.pop_front();
				compare_field("first_serial", want.first_serial, result.first_serial);
				compare_field("second_serial", want.second_serial, result.second_serial);
				compare_field("diff_seconds", want.diff_seconds, result.diff_seconds);
				compare_field("diff_days", 39'(want.diff_days), 39'(result.diff_days));
				results_checked++;
			end
		end
	end

	initial begin : stimulus
		dates_t pair;
		result_t want;
		arst_n = 1'b0;
		dates_valid = 1'b0;
		dates = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			pair = {DIRECTED[i].first_dt, DIRECTED[i].second_dt};
			want = DIRECTED[i].has_answer ? DIRECTED[i].answer : expected_result(pair);
			send_dates(pair, want);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			stall_pct = RECV_STALL[phase];
			repeat (PHASE_ITEMS) begin
				pair = random_dates();
				send_dates(pair, expected_result(pair));
			end
		end
		dates_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("%0d date pairs sent (%0d from the table, the rest random under four",
			dates_sent, NUM_ROWS);
		$display("flow-control mixes); %0d results compared field by field.", results_checked);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d results still outstanding.", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
